@@ hdl/interleaved_string_hash_macros.svh @@
// Assertion macros used by the checker file of the string hash block.
`ifndef INTERLEAVED_STRING_HASH_MACROS_SVH
`define INTERLEAVED_STRING_HASH_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ISH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("string hash check failed");

// Next-cycle implication, disabled while reset is held.
`define ISH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("string hash check failed");

`endif

@@ hdl/ish_pkg.sv @@
package ish_pkg;

    localparam logic [31:0] HashMult = 32'd77;
    localparam logic [31:0] HashBias = 32'd45;
    localparam logic [2:0]  NullLen  = 3'd4;
    localparam logic [2:0]  NullFail = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // fold the accepted character into the accumulators
        logic mult;    // form even accumulator times odd power
        logic finish;  // load the output register and clear the string state
    } t_dp_cmd;

    // Characters of the word that hashes to zero.
    function automatic logic [7:0] null_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h4E;
            2'd1:    c = 8'h55;
            default: c = 8'h4C;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/ish_ifs.sv @@
interface ish_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

interface ish_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

@@ hdl/ish_ctrl.sv @@
module ish_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output ish_pkg::t_dp_cmd o_cmd
);

    ish_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ish_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        accept      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ish_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                o_cmd.load = accept;
                if (accept && i_in_last) begin
                    n_state = ish_pkg::ST_MULT;
                end
            end
            ish_pkg::ST_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = ish_pkg::ST_FIN;
            end
            ish_pkg::ST_FIN: begin
                // hold until the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ish_pkg::ST_IDLE;
                end
            end
            default: n_state = ish_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/ish_dpath.sv @@
module ish_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ish_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_char_code,
    input  logic             i_has_char,
    output logic [31:0]      o_hash_value
);

    logic [31:0] r_even, n_even;
    logic [31:0] r_odd, n_odd;
    logic [31:0] r_power, n_power;
    logic        r_is_odd, n_is_odd;
    logic [2:0]  r_null_prog, n_null_prog;
    logic [31:0] r_prod;
    logic [31:0] r_hash;
    logic [31:0] term;

    // signed byte minus the bias, wrapped to 32 bits
    assign term = {{24{i_char_code[7]}}, i_char_code} - ish_pkg::HashBias;

    always_comb begin
        n_even      = r_even;
        n_odd       = r_odd;
        n_power     = r_power;
        n_is_odd    = r_is_odd;
        n_null_prog = r_null_prog;
        if (i_cmd.finish) begin
            n_even      = '0;
            n_odd       = '0;
            n_power     = 32'd1;
            n_is_odd    = 1'b0;
            n_null_prog = '0;
        end else if (i_cmd.load && i_has_char) begin
            if (r_is_odd) begin
                n_odd   = r_odd * ish_pkg::HashMult + term;
                n_power = r_power * ish_pkg::HashMult;
            end else begin
                n_even  = r_even * ish_pkg::HashMult + term;
            end
            n_is_odd = !r_is_odd;
            if (r_null_prog < ish_pkg::NullLen
                    && i_char_code == ish_pkg::null_char(r_null_prog[1:0])) begin
                n_null_prog = r_null_prog + 3'd1;
            end else begin
                n_null_prog = ish_pkg::NullFail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even      <= '0;
            r_odd       <= '0;
            r_power     <= 32'd1;
            r_is_odd    <= 1'b0;
            r_null_prog <= '0;
        end else begin
            r_even      <= n_even;
            r_odd       <= n_odd;
            r_power     <= n_power;
            r_is_odd    <= n_is_odd;
            r_null_prog <= n_null_prog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mult) begin
            r_prod <= r_even * r_power;
        end
        if (i_cmd.finish) begin
            r_hash <= (r_null_prog == ish_pkg::NullLen) ? 32'd0 : r_prod + r_odd;
        end
    end

    assign o_hash_value = r_hash;

endmodule

@@ hdl/interleaved_string_hash.sv @@
// After the last item, ST_MULT and then ST_FIN bring the hash into the output register.
// Throughput: one character per cycle while idle; the item marked last holds the input
// while the 32x32 combine multiply and the final add run, longer if the output stalls.
// Reset (i_rst_n, synchronous, active low): accumulators to 0, odd power to 1,
// parity and the "NULL" match tracker cleared, output register empty.
module interleaved_string_hash (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ish_in_if.sink    i_in,
    ish_out_if.source o_out
);

    ish_pkg::t_dp_cmd cmd;

    // Controller: accept characters while idle; on last, step through the
    // combine multiply and then load the output register once it is free.
    ish_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Datapath: even and odd chains of h*77 + (c-45), the power 77^n_odd,
    // the "NULL" word tracker, the combine product and the output register.
    ish_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_char_code  (i_in.char_code),
        .i_has_char   (i_in.has_char),
        .o_hash_value (o_out.hash_value)
    );

endmodule

@@ hdl/ish_checker.sv @@
`include "interleaved_string_hash_macros.svh"

module ish_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_hash_value
);

    // Hold a stalled result.
    `ISH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hash_value))

    // Drop ready through the combine states after a final transaction.
    `ISH_ASSERT_NEXT(a_last_stall, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, !i_in_ready)

    `ISH_ASSERT_SAME(a_last_stall2, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_last, ##2 !i_in_ready)

    // A new result only appears straight after a combine cycle.
    `ISH_ASSERT_SAME(a_out_src, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

endmodule

bind interleaved_string_hash ish_checker u_ish_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_hash_value (o_out.hash_value)
);
